// ----- hdl/grid_min_cost_path_macros.svh -----
// Assertion macros for the grid minimum cost path block.
`ifndef GRID_MIN_COST_PATH_MACROS_SVH
`define GRID_MIN_COST_PATH_MACROS_SVH

`ifndef SYNTHESIS
`define GMCP_ASSERT_SAME(label, ant, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);
`define GMCP_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define GMCP_ASSERT_SAME(label, ant, cons, msg)
`define GMCP_ASSERT_NEXT(label, ant, cons, msg)
`endif

`endif

// ----- hdl/gmcp_pkg.sv -----
// Shared types and constants of the grid minimum cost path block.
package gmcp_pkg;

    localparam int DIST_W = 18;
    localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};
    localparam int CFG_W = 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_DRAIN,
        ST_CHECK,
        ST_DONE
    } t_gmcp_state;

    typedef struct packed {
        logic active;
        logic first;
        logic has_a;
        logic has_b;
        logic origin;
        logic last;
        logic clr;
    } t_sweep_ctrl;

    typedef struct packed {
        logic              changed;
        logic [DIST_W-1:0] result;
    } t_relax_stat;

endpackage

// ----- hdl/gmcp_relax.sv -----
// Cost and distance memories with the read, relax and write-back stage.
module gmcp_relax
    import gmcp_pkg::*;
#(
    parameter int MAX_SIDE  = 128,
    parameter int COST_BITS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_sweep_ctrl                          i_ctrl,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] i_addr,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] i_nb_addr,
    input  logic                                 i_cost_we,
    input  logic [3:0]                           i_cost_data,
    output t_relax_stat                          o_stat
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [COST_BITS-1:0] r_cost_mem [DEPTH];
    logic [DIST_W-1:0]    r_dist_mem [DEPTH];

    logic [COST_BITS-1:0] r_rd_cost;
    logic [DIST_W-1:0]    r_rd_old;
    logic [DIST_W-1:0]    r_rd_nb;
    t_sweep_ctrl          r_stage;
    logic [ADDR_W-1:0]    r_waddr;
    logic [DIST_W-1:0]    r_prev;
    logic [DIST_W-1:0]    r_result;
    logic                 r_changed;

    logic [DIST_W-1:0] w_old;
    logic [DIST_W-1:0] w_base;
    logic [DIST_W:0]   w_sum;
    logic [DIST_W-1:0] w_cand;
    logic [DIST_W-1:0] w_new;
    logic              w_better;

    always_ff @(posedge i_clk) begin
        if (i_cost_we) begin
            r_cost_mem[i_addr] <= COST_BITS'(i_cost_data);
        end
        r_rd_cost <= r_cost_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_stage.active) begin
            r_dist_mem[r_waddr] <= w_new;
        end
        r_rd_old <= r_dist_mem[i_addr];
        r_rd_nb  <= r_dist_mem[i_nb_addr];
    end

    always_comb begin
        w_old  = r_stage.first ? DIST_ONES : r_rd_old;
        w_base = r_stage.origin ? '0 : DIST_ONES;
        if (r_stage.has_a && r_rd_nb < w_base) begin
            w_base = r_rd_nb;
        end
        if (r_stage.has_b && r_prev < w_base) begin
            w_base = r_prev;
        end
        w_sum    = {1'b0, w_base} + (DIST_W+1)'(r_rd_cost);
        w_cand   = w_sum[DIST_W] ? DIST_ONES : w_sum[DIST_W-1:0];
        w_better = w_cand < w_old;
        w_new    = w_better ? w_cand : w_old;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= '0;
            r_changed <= 1'b0;
        end else begin
            r_stage <= i_ctrl;
            if (i_ctrl.clr) begin
                r_changed <= 1'b0;
            end else if (r_stage.active && w_better) begin
                r_changed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= i_addr;
        if (r_stage.active) begin
            r_prev <= w_new;
            if (r_stage.last) begin
                r_result <= w_new;
            end
        end
    end

    assign o_stat.changed = r_changed;
    assign o_stat.result  = r_result;

endmodule

// ----- hdl/gmcp_seq.sv -----
// Sequencer for grid loading, alternating sweeps and the result register.
module gmcp_seq
    import gmcp_pkg::*;
#(
    parameter int MAX_SIDE = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [CFG_W-1:0]                     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [DIST_W-1:0]                    o_path_cost,
    input  t_relax_stat                          i_stat,
    output t_sweep_ctrl                          o_ctrl,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] o_addr,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] o_nb_addr,
    output logic                                 o_cost_we
);

    localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int ROW_W  = $clog2(MAX_SIDE);

    t_gmcp_state       r_state, n_state;
    logic [CFG_W-1:0]  r_side;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ROW_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_fwd, n_fwd;
    logic              r_first, n_first;
    logic              r_quiet, n_quiet;
    logic              r_out_valid, n_out_valid;
    logic [DIST_W-1:0] r_out_data, n_out_data;

    logic [CFG_W:0]    w_side_ext;
    logic [SIDE_W-1:0] w_side;
    logic [ROW_W-1:0]  w_side_m1;
    logic [ADDR_W-1:0] w_side_addr;
    logic              w_at_end;
    logic              w_at_origin;
    logic              w_load_acc;
    logic              w_out_free;
    logic              w_stop;
    logic [ROW_W-1:0]  w_fwd_row, w_fwd_col, w_bwd_row, w_bwd_col;

    always_comb begin
        w_side_ext = (r_side == '0) ? (CFG_W+1)'(1) : {1'b0, r_side};
        if (w_side_ext > (CFG_W+1)'(MAX_SIDE)) begin
            w_side = SIDE_W'(MAX_SIDE);
        end else begin
            w_side = SIDE_W'(w_side_ext);
        end
        w_side_m1   = ROW_W'(w_side - SIDE_W'(1));
        w_side_addr = ADDR_W'(w_side);
        w_at_end    = (r_row == w_side_m1) && (r_col == w_side_m1);
        w_at_origin = (r_row == '0) && (r_col == '0);
        w_load_acc  = (r_state == ST_LOAD) && i_in_valid;
        w_out_free  = !r_out_valid || !i_out_stall;
        w_stop      = !i_stat.changed && !r_first && r_quiet;
        if (r_col == w_side_m1) begin
            w_fwd_col = '0;
            w_fwd_row = r_row + ROW_W'(1);
        end else begin
            w_fwd_col = r_col + ROW_W'(1);
            w_fwd_row = r_row;
        end
        if (r_col == '0) begin
            w_bwd_col = w_side_m1;
            w_bwd_row = r_row - ROW_W'(1);
        end else begin
            w_bwd_col = r_col - ROW_W'(1);
            w_bwd_row = r_row;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_load_acc && w_at_end && !i_cfg_we) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_fwd ? w_at_end : w_at_origin) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_CHECK;
            ST_CHECK: n_state = w_stop ? ST_DONE : ST_SWEEP;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.active = (r_state == ST_SWEEP);
        o_ctrl.first  = r_first;
        o_ctrl.has_a  = r_fwd ? (r_row != '0) : (r_row != w_side_m1);
        o_ctrl.has_b  = r_fwd ? (r_col != '0) : (r_col != w_side_m1);
        o_ctrl.origin = w_at_origin;
        o_ctrl.last   = w_at_end;
        o_ctrl.clr    = (r_state == ST_CHECK) && !w_stop;
        o_in_stall    = (r_state != ST_LOAD);
        o_cost_we     = w_load_acc;
        o_addr        = r_addr;
        o_nb_addr     = r_fwd ? (r_addr - w_side_addr) : (r_addr + w_side_addr);
        o_out_valid   = r_out_valid;
        o_path_cost   = r_out_data;
    end

    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        n_addr      = r_addr;
        n_fwd       = r_fwd;
        n_first     = r_first;
        n_quiet     = r_quiet;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        case (r_state)
            ST_LOAD: begin
                if (w_load_acc) begin
                    if (w_at_end) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_addr  = '0;
                        n_fwd   = 1'b1;
                        n_first = 1'b1;
                        n_quiet = 1'b0;
                    end else begin
                        n_row  = w_fwd_row;
                        n_col  = w_fwd_col;
                        n_addr = r_addr + ADDR_W'(1);
                    end
                end
            end
            ST_SWEEP: begin
                if (r_fwd && !w_at_end) begin
                    n_row  = w_fwd_row;
                    n_col  = w_fwd_col;
                    n_addr = r_addr + ADDR_W'(1);
                end else if (!r_fwd && !w_at_origin) begin
                    n_row  = w_bwd_row;
                    n_col  = w_bwd_col;
                    n_addr = r_addr - ADDR_W'(1);
                end
            end
            ST_CHECK: begin
                if (!w_stop) begin
                    n_fwd   = !r_fwd;
                    n_first = 1'b0;
                    n_quiet = !i_stat.changed && !r_first;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = i_stat.result;
                    n_row       = '0;
                    n_col       = '0;
                    n_addr      = '0;
                end
            end
            default: begin
            end
        endcase
        if (i_cfg_we) begin
            n_row  = '0;
            n_col  = '0;
            n_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_side      <= CFG_W'(1);
            r_row       <= '0;
            r_col       <= '0;
            r_addr      <= '0;
            r_fwd       <= 1'b1;
            r_first     <= 1'b0;
            r_quiet     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_addr      <= n_addr;
            r_fwd       <= n_fwd;
            r_first     <= n_first;
            r_quiet     <= n_quiet;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_side <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

// ----- hdl/grid_min_cost_path.sv -----
// Top level of the grid minimum cost path block.
// Cell costs are taken one word per cycle while o_in_stall is low, in
// row-major order into the cost memory. After the last cell the block runs
// relaxation sweeps over the distance memory, alternating forward (using
// the upper and left neighbors) and backward (lower and right neighbors),
// one cell per cycle through its read-modify-write stage; at least three
// sweeps run, until two sweeps in a row change nothing. The first sweep
// writes every distance entry, so no clearing pass is needed. The result
// word then waits in the output register while the next grid loads.
`include "grid_min_cost_path_macros.svh"
module grid_min_cost_path
    import gmcp_pkg::*;
#(
    parameter int MAX_SIDE  = 128,
    parameter int COST_BITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [3:0]        i_cell_cost,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DIST_W-1:0] o_path_cost
);

    localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);

    t_sweep_ctrl       w_ctrl;
    t_relax_stat       w_stat;
    logic [ADDR_W-1:0] w_addr;
    logic [ADDR_W-1:0] w_nb_addr;
    logic              w_cost_we;

    gmcp_seq #(
        .MAX_SIDE(MAX_SIDE)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_path_cost(o_path_cost),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_addr     (w_addr),
        .o_nb_addr  (w_nb_addr),
        .o_cost_we  (w_cost_we)
    );

    gmcp_relax #(
        .MAX_SIDE (MAX_SIDE),
        .COST_BITS(COST_BITS)
    ) u_relax (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_addr     (w_addr),
        .i_nb_addr  (w_nb_addr),
        .i_cost_we  (w_cost_we),
        .i_cost_data(i_cell_cost),
        .o_stat     (w_stat)
    );

    `GMCP_ASSERT_SAME(a_sweep_blocks_input, w_ctrl.active, o_in_stall, "word taken during a sweep")
    `GMCP_ASSERT_SAME(a_load_not_in_sweep, w_cost_we, !w_ctrl.active, "cost write during a sweep")
    `GMCP_ASSERT_NEXT(a_clear_changed, w_ctrl.clr, !w_stat.changed, "change flag not cleared")

endmodule
